// File: rtl/smt_pkg.sv
`default_nettype none

package smt_pkg;

  localparam int PEER_W  = 31;
  localparam int SLOT_W  = 8;
  localparam int SIZE_W  = 5;
  localparam int USED_W  = 9;
  localparam int SLOT_SPAN = 2 ** SLOT_W;

  typedef enum logic [2:0] {
    ACT_SUBSCRIBE   = 3'd0,
    ACT_UNSUBSCRIBE = 3'd1,
    ACT_QUERY       = 3'd2,
    ACT_LIST        = 3'd3,
    ACT_COUNT       = 3'd4,
    ACT_RELEASE     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NOOP = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [SLOT_W-1:0] slot;
    logic [PEER_W-1:0] peer_id;
  } in_item_t;

  typedef struct packed {
    logic [PEER_W-1:0] listed_peer;
    logic              is_member;
    logic [SIZE_W-1:0] row_size;
    logic [USED_W-1:0] slots_in_use;
    logic [1:0]        status;
    logic              last;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/smt_ram.sv
`default_nettype none

module smt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/subscription_membership_table.sv
// An accepted item reads its row count, then scans the row's peers; a removing unsubscribe
// then shifts the later entries of the row down before the result is loaded.
// A list of a non-empty row loads its peers one by one, each read issued only while the
// output register is free; the next item is accepted once the last result is loaded.
// Reset clears the sequencer, the row-count valid bits and the slot total at once;
// the peer storage is not cleared, and the block is ready right after reset.
`default_nettype none

module subscription_membership_table import smt_pkg::*; #(
  parameter int NUM_SLOTS     = 256,
  parameter int PEERS_PER_ROW = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int ROWS = (NUM_SLOTS < SLOT_SPAN) ? NUM_SLOTS : SLOT_SPAN;
  localparam int SW   = $clog2(ROWS);
  localparam int CW   = $clog2(PEERS_PER_ROW + 1);
  localparam int AW   = $clog2(ROWS * PEERS_PER_ROW);
  localparam int TW   = $clog2(ROWS + 1);

  state_t          state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic            slot_ok_r, slot_ok_nxt;
  logic            cval_r, cval_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   pidx_r, pidx_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            pend_r, pend_nxt;
  logic            found_r, found_nxt;
  logic [ROWS-1:0] row_vld_r, row_vld_nxt;
  logic [TW-1:0]   tot_r, tot_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            accept, out_free;
  logic            scan_issue, scan_done, shift_issue, shift_done;
  logic            list_issue, list_load, list_end, fin_go;
  logic [SW-1:0]   in_slot_idx;

  logic            cnt_we;
  logic [CW-1:0]   cnt_wdata, cnt_rdata;
  logic            prd_en, pwe;
  logic [AW-1:0]   prd_addr, pwr_addr;
  logic [PEER_W-1:0] pwr_data, prd_data;

  out_item_t       fin_res;
  logic            fin_cnt_we, fin_peer_we, tot_inc, tot_dec;
  logic [CW-1:0]   fin_cnt;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign in_slot_idx = in_data.slot[SW-1:0];

  assign scan_issue  = (state_r == S_SCAN) && (idx_r < n_r);
  assign scan_done   = (state_r == S_SCAN) && (idx_r == n_r) && !pend_r;
  assign shift_issue = (state_r == S_SHIFT) && (idx_r < n_r);
  assign shift_done  = (state_r == S_SHIFT) && (idx_r == n_r) && !pend_r;
  assign list_issue  = (state_r == S_LIST) && !pend_r && (idx_r < n_r) && out_free;
  assign list_load   = (state_r == S_LIST) && pend_r;
  assign list_end    = list_load && (pidx_r == n_r - CW'(1));
  assign fin_go      = (state_r == S_FIN) && out_free;

  smt_ram #(.WIDTH(CW), .DEPTH(ROWS)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (item_r.slot[SW-1:0]),
    .wr_data (cnt_wdata),
    .rd_en   (accept),
    .rd_addr (in_slot_idx),
    .rd_data (cnt_rdata)
  );

  smt_ram #(.WIDTH(PEER_W), .DEPTH(ROWS * PEERS_PER_ROW)) u_peer_ram (
    .clk     (clk),
    .wr_en   (pwe),
    .wr_addr (pwr_addr),
    .wr_data (pwr_data),
    .rd_en   (prd_en),
    .rd_addr (prd_addr),
    .rd_data (prd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) begin
          if (item_r.action == ACT_LIST && n_r != '0) begin
            state_nxt = S_LIST;
          end else if (item_r.action == ACT_UNSUBSCRIBE && found_r) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_nxt = S_FIN;
        end
      end
      S_LIST: begin
        if (list_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fin_res              = '0;
    fin_res.is_member    = found_r;
    fin_res.row_size     = SIZE_W'(n_r);
    fin_res.status       = STAT_DONE;
    fin_res.last         = 1'b1;
    fin_cnt_we           = 1'b0;
    fin_peer_we          = 1'b0;
    fin_cnt              = n_r;
    tot_inc              = 1'b0;
    tot_dec              = 1'b0;
    if (!slot_ok_r) begin
      fin_res.status = STAT_NOOP;
    end else begin
      case (item_r.action)
        ACT_SUBSCRIBE: begin
          if (found_r) begin
            fin_res.status = STAT_NOOP;
          end else if (n_r >= CW'(PEERS_PER_ROW)) begin
            fin_res.status = STAT_FULL;
          end else begin
            fin_peer_we       = 1'b1;
            fin_cnt_we        = 1'b1;
            fin_cnt           = n_r + CW'(1);
            tot_inc           = (n_r == '0);
            fin_res.is_member = 1'b1;
            fin_res.row_size  = SIZE_W'(n_r + CW'(1));
          end
        end
        ACT_UNSUBSCRIBE: begin
          if (!found_r) begin
            fin_res.status = STAT_NOOP;
          end else begin
            fin_cnt_we        = 1'b1;
            fin_cnt           = n_r - CW'(1);
            tot_dec           = (n_r == CW'(1));
            fin_res.is_member = 1'b0;
            fin_res.row_size  = SIZE_W'(n_r - CW'(1));
          end
        end
        ACT_QUERY, ACT_COUNT: begin
          fin_res.status = STAT_DONE;
        end
        ACT_LIST: begin
          fin_res.status = STAT_NOOP;
        end
        ACT_RELEASE: begin
          if (n_r == '0) begin
            fin_res.status = STAT_NOOP;
          end else begin
            fin_cnt_we        = 1'b1;
            fin_cnt           = '0;
            tot_dec           = 1'b1;
            fin_res.is_member = 1'b0;
            fin_res.row_size  = '0;
          end
        end
        default: begin
          fin_res.status = STAT_NOOP;
        end
      endcase
    end
    fin_res.slots_in_use = USED_W'(tot_r);
  end

  always_comb begin
    item_nxt      = item_r;
    base_nxt      = base_r;
    slot_ok_nxt   = slot_ok_r;
    cval_nxt      = cval_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    row_vld_nxt   = row_vld_r;
    tot_nxt       = tot_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cnt_we        = 1'b0;
    cnt_wdata     = fin_cnt;
    prd_en        = 1'b0;
    prd_addr      = base_r + AW'(idx_r);
    pwe           = 1'b0;
    pwr_addr      = base_r + AW'(n_r);
    pwr_data      = item_r.peer_id;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      item_nxt    = in_data;
      base_nxt    = AW'(32'(in_data.slot) * PEERS_PER_ROW);
      slot_ok_nxt = 32'(in_data.slot) < ROWS;
      cval_nxt    = (32'(in_data.slot) < ROWS) && row_vld_r[in_slot_idx];
      found_nxt   = 1'b0;
      pend_nxt    = 1'b0;
      idx_nxt     = '0;
      pos_nxt     = '0;
    end

    if (state_r == S_CNT) begin
      n_nxt = cval_r ? cnt_rdata : '0;
    end

    if (state_r == S_SCAN) begin
      pend_nxt = scan_issue;
      if (scan_issue) begin
        prd_en   = 1'b1;
        pidx_nxt = idx_r;
        idx_nxt  = idx_r + CW'(1);
      end
      if (pend_r && !found_r && prd_data == item_r.peer_id) begin
        found_nxt = 1'b1;
        pos_nxt   = pidx_r;
      end
      if (scan_done) begin
        idx_nxt = (item_r.action == ACT_LIST) ? '0 : pos_r + CW'(1);
      end
    end

    if (state_r == S_SHIFT) begin
      pend_nxt = shift_issue;
      if (shift_issue) begin
        prd_en   = 1'b1;
        pidx_nxt = idx_r;
        idx_nxt  = idx_r + CW'(1);
      end
      if (pend_r) begin
        pwe      = 1'b1;
        pwr_addr = base_r + AW'(pidx_r - CW'(1));
        pwr_data = prd_data;
      end
    end

    if (list_issue) begin
      prd_en   = 1'b1;
      pidx_nxt = idx_r;
      idx_nxt  = idx_r + CW'(1);
      pend_nxt = 1'b1;
    end
    if (list_load) begin
      pend_nxt                  = 1'b0;
      out_valid_nxt             = 1'b1;
      out_data_nxt.listed_peer  = prd_data;
      out_data_nxt.is_member    = found_r;
      out_data_nxt.row_size     = SIZE_W'(n_r);
      out_data_nxt.slots_in_use = USED_W'(tot_r);
      out_data_nxt.status       = STAT_DONE;
      out_data_nxt.last         = (pidx_r == n_r - CW'(1));
    end

    if (fin_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = fin_res;
      if (fin_peer_we) begin
        pwe = 1'b1;
      end
      if (fin_cnt_we) begin
        cnt_we                               = 1'b1;
        row_vld_nxt[item_r.slot[SW-1:0]]     = 1'b1;
      end
      if (tot_inc) begin
        tot_nxt                   = tot_r + TW'(1);
        out_data_nxt.slots_in_use = USED_W'(tot_r + TW'(1));
      end else if (tot_dec) begin
        tot_nxt                   = tot_r - TW'(1);
        out_data_nxt.slots_in_use = USED_W'(tot_r - TW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      row_vld_r   <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      row_vld_r   <= row_vld_nxt;
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    base_r     <= base_nxt;
    slot_ok_r  <= slot_ok_nxt;
    cval_r     <= cval_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/smt_checker.sv
`default_nettype none

module smt_checker import smt_pkg::*; #(
  parameter int PEERS_PER_ROW = 16
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A result that is stalled keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_full_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_FULL |->
      !out_data.is_member && out_data.row_size == SIZE_W'(PEERS_PER_ROW))
    else $error("dropped subscribe reports a row that is not full");

  a_listed_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.listed_peer != '0 |-> out_data.status == STAT_DONE)
    else $error("listed peer on a result that is not a list entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready again right after taking an item");

endmodule

bind subscription_membership_table smt_checker #(.PEERS_PER_ROW(PEERS_PER_ROW))
  u_smt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
